@@ src/qrs_pkg.sv @@
package qrs_pkg;

    localparam int COEF_WIDTH_DEF = 16;
    localparam int ROOT_WIDTH     = 40;
    localparam int ROOT_FRAC_BITS = 16;

    localparam logic [1:0] ST_TWO_ROOTS    = 2'd0;
    localparam logic [1:0] ST_DOUBLE_ROOT  = 2'd1;
    localparam logic [1:0] ST_NO_REAL      = 2'd2;
    localparam logic [1:0] ST_NOT_QUAD     = 2'd3;

endpackage

@@ src/qrs_if.sv @@
interface qrs_coef_if #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_root_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           root_status;
    logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_first;
    logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_second;

    modport source (output valid, output root_status, output root_first, output root_second,
                    input ready);
    modport sink (input valid, input root_status, input root_first, input root_second,
                  output ready);
endinterface

@@ src/quadratic_root_solver.sv @@
// Quadratic root solver.
// Each transaction on i_in carries signed coefficients A, B and C of A*x^2 + B*x + C = 0.
// Each transaction on o_out returns a status and the two real roots in signed Q24.16.
// Status is two distinct roots, one double root, no real roots, or not quadratic; the
// roots are zero for the last two. Roots are (-B +/- isqrt(D)) / (2A), truncated toward zero.
// The block is a pipeline: one multiply stage, one discriminant stage, one square root
// stage per result bit (COEF_WIDTH + 1 stages), one numerator stage, one divide stage per
// quotient bit (COEF_WIDTH + 18 stages, both roots in parallel) and an output register.
// A new transaction is accepted every cycle while i_in.ready is high.
// When the receiver stalls, results stay in the output register and the pipeline keeps
// filling its empty stages; i_in.ready drops only once every stage holds a result.
// Reset clears all valid bits; no output appears until new transactions arrive.
module quadratic_root_solver #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    qrs_coef_if.sink     i_in,
    qrs_root_if.source   o_out
);
    import qrs_pkg::*;

    localparam int W   = COEF_WIDTH;
    localparam int DW  = 2 * W + 2;
    localparam int TW  = 2 * W + 3;
    localparam int SW  = W + 1;
    localparam int NW  = W + 3;
    localparam int MW  = W + 2;
    localparam int RW  = W + 2;
    localparam int QN  = MW + ROOT_FRAC_BITS;
    localparam int NP  = SW + 3 + QN;
    localparam int XW  = (QN + 2 > ROOT_WIDTH + 1) ? QN + 2 : ROOT_WIDTH + 1;
    localparam logic signed [XW-1:0] RMAX = (XW'(1) << (ROOT_WIDTH - 1)) - XW'(1);
    localparam logic signed [XW-1:0] RMIN = -(XW'(1) << (ROOT_WIDTH - 1));

    typedef struct packed {
        logic [1:0]              status;
        logic                    a_neg;
        logic                    ac_neg;
        logic signed [W-1:0]     b;
        logic [2*W-1:0]          bb;
        logic [2*W-1:0]          ac;
        logic [W:0]              den;
        logic [TW-1:0]           srem;
        logic [SW-1:0]           sroot;
        logic [1:0]              q_neg;
        logic [1:0][QN-1:0]      dvd;
        logic [1:0][RW-1:0]      drem;
        logic [1:0][QN-1:0]      quo;
    } t_st;

    logic          r_v [NP];
    t_st           r_d [NP];
    logic          rdy [NP+1];

    logic                          r_ov;
    logic [1:0]                    r_status;
    logic signed [ROOT_WIDTH-1:0]  r_root1;
    logic signed [ROOT_WIDTH-1:0]  r_root2;
    logic [1:0]                    n_status;
    logic signed [ROOT_WIDTH-1:0]  n_root [2];

    assign rdy[NP]   = !r_ov || o_out.ready;
    assign i_in.ready = rdy[0];

    for (genvar i = 0; i < NP; i++) begin : g_st
        t_st  n_d;
        logic v_in;

        assign rdy[i] = !r_v[i] || rdy[i+1];

        if (i == 0) begin : g_mul
            logic [W-1:0] ma, mb, mc;
            assign v_in = i_in.valid;
            always_comb begin
                ma = i_in.coef_a[W-1] ? W'(-i_in.coef_a) : W'(i_in.coef_a);
                mb = i_in.coef_b[W-1] ? W'(-i_in.coef_b) : W'(i_in.coef_b);
                mc = i_in.coef_c[W-1] ? W'(-i_in.coef_c) : W'(i_in.coef_c);
                n_d        = '0;
                n_d.status = (i_in.coef_a == '0) ? ST_NOT_QUAD : ST_TWO_ROOTS;
                n_d.a_neg  = i_in.coef_a[W-1];
                n_d.ac_neg = (i_in.coef_a != '0) && (i_in.coef_c != '0)
                             && (i_in.coef_a[W-1] != i_in.coef_c[W-1]);
                n_d.b      = i_in.coef_b;
                n_d.bb     = (2*W)'(mb) * (2*W)'(mb);
                n_d.ac     = (2*W)'(ma) * (2*W)'(mc);
                n_d.den    = {ma, 1'b0};
            end
        end else if (i == 1) begin : g_disc
            logic [DW-1:0] q4, bbx;
            assign v_in = r_v[i-1];
            always_comb begin
                n_d  = r_d[i-1];
                q4   = {r_d[i-1].ac, 2'b00};
                bbx  = DW'(r_d[i-1].bb);
                n_d.srem = '0;
                if (r_d[i-1].status != ST_NOT_QUAD) begin
                    if (r_d[i-1].ac_neg) begin
                        n_d.srem = TW'(bbx + q4);
                    end else if (bbx < q4) begin
                        n_d.status = ST_NO_REAL;
                    end else begin
                        n_d.srem = TW'(bbx - q4);
                    end
                    if (n_d.status == ST_TWO_ROOTS && n_d.srem == '0) begin
                        n_d.status = ST_DOUBLE_ROOT;
                    end
                end
                n_d.sroot = '0;
            end
        end else if (i < SW + 2) begin : g_sqrt
            localparam int K = SW - 1 - (i - 2);
            logic [TW-1:0] trial;
            assign v_in = r_v[i-1];
            always_comb begin
                n_d   = r_d[i-1];
                trial = ((TW'(r_d[i-1].sroot) << 1) | (TW'(1) << K)) << K;
                if (trial <= r_d[i-1].srem) begin
                    n_d.srem  = r_d[i-1].srem - trial;
                    n_d.sroot = r_d[i-1].sroot | (SW'(1) << K);
                end
            end
        end else if (i == SW + 2) begin : g_num
            logic signed [NW-1:0] num [2];
            logic [MW-1:0]        mag [2];
            assign v_in = r_v[i-1];
            always_comb begin
                n_d    = r_d[i-1];
                num[0] = -NW'(r_d[i-1].b) + NW'(signed'({1'b0, r_d[i-1].sroot}));
                num[1] = -NW'(r_d[i-1].b) - NW'(signed'({1'b0, r_d[i-1].sroot}));
                for (int l = 0; l < 2; l++) begin
                    mag[l]        = num[l][NW-1] ? MW'(-num[l]) : MW'(num[l]);
                    n_d.q_neg[l]  = num[l][NW-1] ^ r_d[i-1].a_neg;
                    n_d.dvd[l]    = {mag[l], {ROOT_FRAC_BITS{1'b0}}};
                    n_d.drem[l]   = '0;
                    n_d.quo[l]    = '0;
                end
            end
        end else begin : g_div
            logic [RW-1:0] tmp [2];
            assign v_in = r_v[i-1];
            always_comb begin
                n_d = r_d[i-1];
                for (int l = 0; l < 2; l++) begin
                    tmp[l]     = {r_d[i-1].drem[l][RW-2:0], r_d[i-1].dvd[l][QN-1]};
                    n_d.dvd[l] = r_d[i-1].dvd[l] << 1;
                    if (tmp[l] >= RW'(r_d[i-1].den)) begin
                        n_d.drem[l] = tmp[l] - RW'(r_d[i-1].den);
                        n_d.quo[l]  = {r_d[i-1].quo[l][QN-2:0], 1'b1};
                    end else begin
                        n_d.drem[l] = tmp[l];
                        n_d.quo[l]  = {r_d[i-1].quo[l][QN-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (rdy[i]) begin
                r_v[i] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[i] && v_in) begin
                r_d[i] <= n_d;
            end
        end
    end

    logic signed [XW-1:0] val [2];

    always_comb begin
        n_status = r_d[NP-1].status;
        for (int l = 0; l < 2; l++) begin
            val[l] = signed'(XW'(r_d[NP-1].quo[l]));
            if (r_d[NP-1].q_neg[l]) begin
                val[l] = -val[l];
            end
            if (val[l] > RMAX) begin
                val[l] = RMAX;
            end else if (val[l] < RMIN) begin
                val[l] = RMIN;
            end
            if (n_status == ST_NO_REAL || n_status == ST_NOT_QUAD) begin
                n_root[l] = '0;
            end else begin
                n_root[l] = val[l][ROOT_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (rdy[NP]) begin
            r_ov <= r_v[NP-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[NP] && r_v[NP-1]) begin
            r_status <= n_status;
            r_root1  <= n_root[0];
            r_root2  <= n_root[1];
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.root_status = r_status;
    assign o_out.root_first  = r_root1;
    assign o_out.root_second = r_root2;

endmodule

@@ src/qrs_checker.sv @@
module qrs_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_out_valid,
    input logic                                  i_out_ready,
    input logic [1:0]                            i_status,
    input logic signed [qrs_pkg::ROOT_WIDTH-1:0] i_root_first,
    input logic signed [qrs_pkg::ROOT_WIDTH-1:0] i_root_second
);
    import qrs_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("Output valid right after reset.");

    a_zero_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_NO_REAL || i_status == ST_NOT_QUAD)
        |-> i_root_first == '0 && i_root_second == '0)
        else $error("Roots must be zero without real roots.");

    a_double_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_DOUBLE_ROOT |-> i_root_first == i_root_second)
        else $error("Double root with unequal roots.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
        && $stable(i_root_first) && $stable(i_root_second))
        else $error("Stalled transaction changed.");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_status      (o_out.root_status),
    .i_root_first  (o_out.root_first),
    .i_root_second (o_out.root_second)
);

@@ tb/quadratic_root_solver_checker.sv @@
`timescale 1ns / 1ps

module quadratic_root_solver_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qrs_coef_if.sink    i_in,
    qrs_root_if.sink    i_out,
    output int          o_fail_count,
    output int          o_pending,
    output logic        o_moved
);
    import qrs_pkg::*;

    typedef struct packed {
        logic [1:0]                   status;
        logic signed [ROOT_WIDTH-1:0] first;
        logic signed [ROOT_WIDTH-1:0] second;
    } t_roots;

    t_roots expected_roots[$];
    int     fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_roots.size();
    assign o_moved      = (i_in.valid && i_in.ready) || (i_out.valid && i_out.ready);

    function automatic logic signed [ROOT_WIDTH-1:0] scaled_ratio(longint num, longint den);
        longint q;
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (ROOT_WIDTH - 1)) - 1;
        lo = -(longint'(1) <<< (ROOT_WIDTH - 1));
        q = (num * (longint'(1) <<< ROOT_FRAC_BITS)) / den;
        if (q > hi) q = hi;
        if (q < lo) q = lo;
        return q[ROOT_WIDTH-1:0];
    endfunction

    function automatic longint floor_sqrt(longint d);
        longint       r;
        longint       t;
        logic [127:0] sq;
        r = 0;
        for (int k = 33; k >= 0; k--) begin
            t = r | (longint'(1) <<< k);
            sq = 128'(t) * 128'(t);
            if (sq <= 128'(d)) r = t;
        end
        return r;
    endfunction

    function automatic t_roots solve_quadratic(logic signed [15:0] ca, logic signed [15:0] cb,
                                               logic signed [15:0] cc);
        t_roots r;
        longint a;
        longint b;
        longint disc;
        longint s;
        a = ca;
        b = cb;
        disc = b * b - 4 * a * longint'(cc);
        r = '0;
        if (a == 0) begin
            r.status = ST_NOT_QUAD;
        end else if (disc < 0) begin
            r.status = ST_NO_REAL;
        end else begin
            s = floor_sqrt(disc);
            r.status = (disc == 0) ? ST_DOUBLE_ROOT : ST_TWO_ROOTS;
            r.first  = scaled_ratio(-b + s, 2 * a);
            r.second = scaled_ratio(-b - s, 2 * a);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_roots want;
        if (!i_rst_n) begin
            fail_count = 0;
            expected_roots.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                expected_roots.push_back(solve_quadratic(i_in.coef_a, i_in.coef_b,
                                                         i_in.coef_c));
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_roots.size() == 0) begin
                    report_mismatch("unexpected transaction", i_out.root_status, -1);
                end else begin
                    want = expected_roots.pop_front();
                    if (i_out.root_status !== want.status)
                        report_mismatch("status", i_out.root_status, want.status);
                    if (i_out.root_first !== want.first)
                        report_mismatch("first root", i_out.root_first, want.first);
                    if (i_out.root_second !== want.second)
                        report_mismatch("second root", i_out.root_second, want.second);
                end
            end
        end
    end
endmodule

@@ tb/quadratic_root_solver_test.sv @@
`timescale 1ns / 1ps

module quadratic_root_solver_test;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int RANDOM_ITEMS   = 1700;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    logic moved;
    int   idle_cycles;
    int   send_idle_pct;
    int   stall_pct;

    qrs_coef_if coef_bus ();
    qrs_root_if root_bus ();

    quadratic_root_solver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (coef_bus.sink),
        .o_out   (root_bus.source)
    );

    quadratic_root_solver_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (coef_bus.sink),
        .i_out        (root_bus.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_moved      (moved)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            root_bus.ready <= 1'b0;
        end else begin
            root_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || moved) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            coef_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        coef_bus.valid  <= 1'b1;
        coef_bus.coef_a <= a;
        coef_bus.coef_b <= b;
        coef_bus.coef_c <= c;
        @(posedge i_clk);
        while (!coef_bus.ready) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(64)) - 32);
            3: return 16'($urandom_range(1, 16) << 8) ^ {16{1'($urandom_range(1))}};
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] a;
        logic [15:0] b;
        coef_bus.valid  <= 1'b0;
        coef_bus.coef_a <= '0;
        coef_bus.coef_b <= '0;
        coef_bus.coef_c <= '0;
        send_idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_coefs(16'h0000, 16'h0100, 16'h0100);
        send_coefs(16'h0000, 16'h0000, 16'h0000);
        send_coefs(16'h0100, 16'hfd00, 16'h0200);
        send_coefs(16'h0100, 16'hfe00, 16'h0100);
        send_coefs(16'h0100, 16'h0000, 16'h0100);
        send_coefs(16'h8000, 16'h8000, 16'h8000);
        send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
        send_coefs(16'h8000, 16'h7fff, 16'h7fff);
        send_coefs(16'h7fff, 16'h8000, 16'h8000);
        send_coefs(16'h0001, 16'h8000, 16'h8000);
        send_coefs(16'hffff, 16'h7fff, 16'h0000);
        send_coefs(16'h0001, 16'h0002, 16'h0001);
        send_coefs(16'hffff, 16'h0003, 16'hffff);
        send_coefs(16'hffff, 16'hffff, 16'hffff);
        send_coefs(16'h5555, 16'haaaa, 16'h5555);
        send_coefs(16'haaaa, 16'h5555, 16'haaaa);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case ((i * 5) / RANDOM_ITEMS)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 76; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 76; end
                3: begin send_idle_pct = 21; stall_pct = 21; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            if ($urandom_range(3) == 0) begin
                a = 16'(int'($urandom_range(32)) - 16);
                b = 16'(2 * int'($urandom_range(64)) - 64);
                send_coefs(a, b, 16'(($signed(b) / 2) * ($signed(b) / 2)
                                     / (($signed(a) == 0) ? 1 : $signed(a))));
            end else begin
                send_coefs(pick_coef(), pick_coef(), pick_coef());
            end
        end
        coef_bus.valid <= 1'b0;
        stall_pct = 0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
src/qrs_pkg.sv
src/qrs_if.sv
src/quadratic_root_solver.sv
src/qrs_checker.sv
tb/quadratic_root_solver_checker.sv
tb/quadratic_root_solver_test.sv
